// ----- rtl/core/solenoid_pulse_train_generator_top_assert.svh -----
// assertion macros for the pulse train generator
`ifndef SOLENOID_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`define SOLENOID_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH

// clocked check, switched off while in reset
`define SPTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define SPTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sptg_pkg.sv -----
package sptg_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PULSE_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2000;
  localparam logic [DUTY_W-1:0]   DUTY_RST   = 7'd10;
  localparam logic [DUTY_W-1:0]   DUTY_MAX   = 7'd100;
  localparam logic [PROD_W-1:0]   PROD_RST   = 23'd20000;
  localparam logic [PERIOD_W-1:0] ON_LEN_RST = 16'd200;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^23
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
  localparam int unsigned RPROD_W = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_TIME = 3'd1,
    CMD_ARM      = 3'd2,
    CMD_FORCE_ON = 3'd3,
    CMD_FORCE_OFF = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_DUTY   = 2'd1,
    CFG_LEVEL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_READY = 3'b001,
    PH_FIRE  = 3'b010,
    PH_REST  = 3'b100
  } phase_e;

  localparam logic [1:0] PHASE_CODE_READY = 2'd0;
  localparam logic [1:0] PHASE_CODE_FIRE  = 2'd1;
  localparam logic [1:0] PHASE_CODE_REST  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [NOW_W-1:0]   now_ms;
    logic [PULSE_W-1:0] pulse_count;
  } in_item_t;

  typedef struct packed {
    logic               drive_level;
    logic [1:0]         phase;
    logic [PULSE_W-1:0] pulses_fired;
    logic               busy_res;
  } out_item_t;

endpackage

// ----- rtl/core/solenoid_pulse_train_generator_top.sv -----
// an item taken into the input register has its result written to the output register once the output is not stalled
// throughput: one item per cycle while the output is not stalled, set by the single state update stage
// on-time is refreshed after a period or duty write, first into prod_q and then into on_len_q
// reset: asynchronous active low, clears all state and the pipeline,
// loads period 2000, duty 10, active level 1
module solenoid_pulse_train_generator_top #(
  parameter int unsigned TIME_WIDTH  = sptg_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = sptg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  sptg_pkg::in_item_t                      in_item_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output sptg_pkg::out_item_t                     out_item_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [sptg_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sptg_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import sptg_pkg::*;

  logic                   cfg_we;
  logic [PERIOD_W-1:0]    period_q;
  logic [DUTY_W-1:0]      duty_q;
  logic                   level_q;
  logic [DUTY_W-1:0]      duty_sat;
  logic [PERIOD_W-1:0]    mul_a;
  logic [DUTY_W-1:0]      mul_b;
  logic [PROD_W-1:0]      prod_q;
  logic [RPROD_W-1:0]     rprod;
  logic [PERIOD_W-1:0]    on_len_q;
  logic [PERIOD_W-1:0]    off_len;

  logic                   adv;
  logic                   proc;
  logic                   in_vld_q;
  in_item_t               in_q;
  logic                   out_vld_q;
  out_item_t              out_q;
  out_item_t              out_d;

  phase_e                 phase_q, phase_d;
  logic [TIME_WIDTH-1:0]  start_q, start_d;
  logic [TIME_WIDTH-1:0]  stored_q, stored_d;
  logic [COUNT_WIDTH-1:0] fired_q, fired_d;
  logic [COUNT_WIDTH-1:0] goal_q, goal_d;
  logic                   train_q, train_d;
  logic                   pin_q, pin_d;
  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   pulse_end;

  // configuration and on-time
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign duty_sat    = (cfg_data_i[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX
                                                           : cfg_data_i[DUTY_W-1:0];
  assign mul_a = (cfg_index_i == CFG_PERIOD) ? cfg_data_i[PERIOD_W-1:0] : period_q;
  assign mul_b = (cfg_index_i == CFG_DUTY) ? duty_sat : duty_q;
  assign rprod = RPROD_W'(prod_q) * RPROD_W'(RECIP_100);
  assign off_len = period_q - on_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      duty_q   <= DUTY_RST;
      level_q  <= 1'b1;
      prod_q   <= PROD_RST;
      on_len_q <= ON_LEN_RST;
    end else begin
      on_len_q <= rprod[RECIP_SHIFT +: PERIOD_W];
      if (cfg_we) begin
        prod_q <= PROD_W'(mul_a * PROD_W'(mul_b));
        unique case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_DUTY:   duty_q   <= duty_sat;
          CFG_LEVEL:  level_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // pipeline control
  assign adv        = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (proc) begin
      out_q <= out_d;
    end
  end

  // command processing
  assign now_t   = TIME_WIDTH'(in_q.now_ms);
  assign elapsed = now_t - start_q;

  always_comb begin
    phase_d  = phase_q;
    start_d  = start_q;
    stored_d = stored_q;
    fired_d  = fired_q;
    goal_d   = goal_q;
    train_d  = train_q;
    pin_d    = pin_q;
    if (proc) begin
      case (in_q.cmd)
        CMD_TICK: begin
          stored_d = now_t;
          if (fired_q < goal_q) begin
            train_d = 1'b1;
          end
          if (train_d) begin
            unique case (phase_q)
              PH_READY: begin
                start_d = now_t;
                phase_d = PH_FIRE;
                pin_d   = level_q;
              end
              PH_FIRE: begin
                if (TIME_WIDTH'(on_len_q) < elapsed) begin
                  start_d = now_t;
                  phase_d = PH_REST;
                  pin_d   = ~level_q;
                end
              end
              PH_REST: begin
                pin_d = ~level_q;
                if (TIME_WIDTH'(off_len) < elapsed) begin
                  phase_d = PH_READY;
                  fired_d = fired_q + 1'b1;
                  train_d = 1'b0;
                  start_d = now_t;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_SET_TIME: stored_d = now_t;
        CMD_ARM: begin
          train_d = 1'b1;
          goal_d  = COUNT_WIDTH'(in_q.pulse_count);
          fired_d = '0;
        end
        CMD_FORCE_ON: begin
          pin_d   = level_q;
          phase_d = PH_FIRE;
          start_d = stored_q;
        end
        CMD_FORCE_OFF: begin
          pin_d   = ~level_q;
          phase_d = PH_REST;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d.drive_level  = pin_d;
    out_d.pulses_fired = PULSE_W'(fired_d);
    out_d.busy_res     = train_d;
    unique case (phase_d)
      PH_READY: out_d.phase = PHASE_CODE_READY;
      PH_FIRE:  out_d.phase = PHASE_CODE_FIRE;
      PH_REST:  out_d.phase = PHASE_CODE_REST;
      default:  out_d.phase = PHASE_CODE_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_READY;
      start_q  <= '0;
      stored_q <= '0;
      fired_q  <= '0;
      goal_q   <= '0;
      train_q  <= 1'b0;
      pin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      stored_q <= stored_d;
      fired_q  <= fired_d;
      goal_q   <= goal_d;
      train_q  <= train_d;
      pin_q    <= pin_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // a tick that closes the resting phase
  assign pulse_end = proc && (in_q.cmd == CMD_TICK) && (phase_q == PH_REST) &&
                     (phase_d == PH_READY);

`include "solenoid_pulse_train_generator_top_assert.svh"

  `SPTG_ASSERT_NEXT(a_held_item_kept, in_vld_q && out_vld_q && out_stall_i, in_vld_q,
    "held item lost")
  `SPTG_ASSERT(a_on_len_bound, !$past(cfg_we) |-> (on_len_q <= period_q),
    "on-time above period")
  `SPTG_ASSERT(a_result_from_item, $rose(out_vld_q) |-> $past(in_vld_q), "result without item")
  `SPTG_ASSERT_NEXT(a_pulse_count, pulse_end,
    (fired_q == COUNT_WIDTH'($past(fired_q) + 1'b1)) && !train_q, "pulse end not counted")

endmodule

// ----- tb/sv/solenoid_pulse_train_checker.sv -----
module solenoid_pulse_train_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  sptg_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  sptg_pkg::out_item_t             out_item_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sptg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sptg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              pulses_o
);
  import sptg_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   duty_q;
  logic                level_q;

  logic [1:0]         phase_q;
  logic [NOW_W-1:0]   phase_start_ms;
  logic [NOW_W-1:0]   stamp_ms;
  logic [PULSE_W-1:0] fired_q;
  logic [PULSE_W-1:0] goal_q;
  logic               train_q;
  logic               pin_q;

  out_item_t predicted_drive_q[$];
  out_item_t wanted;
  out_item_t guess;

  int mismatches = 0;
  int waiting = 0;
  int results = 0;
  int pulses = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;
  assign results_o    = results;
  assign pulses_o     = pulses;

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PERIOD: period_q = val[PERIOD_W-1:0];
      CFG_DUTY: duty_q = (val[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX : val[DUTY_W-1:0];
      CFG_LEVEL: level_q = val[0];
      default: ;
    endcase
  endtask

  task automatic advance_solenoid(input in_item_t it);
    logic [31:0]      prod;
    logic [NOW_W-1:0] on_ms;
    logic [NOW_W-1:0] off_ms;
    logic [NOW_W-1:0] elapsed;
    case (it.cmd)
      CMD_TICK: begin
        stamp_ms = it.now_ms;
        if (fired_q < goal_q) train_q = 1'b1;
        if (train_q) begin
          prod    = period_q * duty_q;
          on_ms   = prod / DUTY_MAX;
          off_ms  = period_q - on_ms;
          elapsed = stamp_ms - phase_start_ms;
          case (phase_q)
            PHASE_CODE_READY: begin
              phase_start_ms = stamp_ms;
              phase_q        = PHASE_CODE_FIRE;
              pin_q          = level_q;
            end
            PHASE_CODE_FIRE: begin
              if (elapsed > on_ms) begin
                phase_start_ms = stamp_ms;
                phase_q        = PHASE_CODE_REST;
                pin_q          = ~level_q;
              end
            end
            PHASE_CODE_REST: begin
              pin_q = ~level_q;
              if (elapsed > off_ms) begin
                phase_q        = PHASE_CODE_READY;
                fired_q        = fired_q + 1'b1;
                train_q        = 1'b0;
                phase_start_ms = stamp_ms;
                pulses++;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_SET_TIME: stamp_ms = it.now_ms;
      CMD_ARM: begin
        train_q = 1'b1;
        goal_q  = it.pulse_count;
        fired_q = '0;
      end
      CMD_FORCE_ON: begin
        pin_q          = level_q;
        phase_q        = PHASE_CODE_FIRE;
        phase_start_ms = stamp_ms;
      end
      CMD_FORCE_OFF: begin
        pin_q   = ~level_q;
        phase_q = PHASE_CODE_REST;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       = PERIOD_RST;
      duty_q         = DUTY_RST;
      level_q        = 1'b1;
      phase_q        = PHASE_CODE_READY;
      phase_start_ms = '0;
      stamp_ms       = '0;
      fired_q        = '0;
      goal_q         = '0;
      train_q        = 1'b0;
      pin_q          = 1'b0;
      predicted_drive_q.delete();
      waiting = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_setting(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (predicted_drive_q.size() == 0) begin
          $error("result with no expectation waiting: %p", out_item_i);
          mismatches++;
        end else begin
          wanted = predicted_drive_q.pop_front();
          waiting--;
          results++;
          check_field("drive_level", 8'(wanted.drive_level), 8'(out_item_i.drive_level));
          check_field("phase", 8'(wanted.phase), 8'(out_item_i.phase));
          check_field("pulses_fired", wanted.pulses_fired, out_item_i.pulses_fired);
          check_field("busy_res", 8'(wanted.busy_res), 8'(out_item_i.busy_res));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_solenoid(in_item_i);
        guess.drive_level  = pin_q;
        guess.phase        = phase_q;
        guess.pulses_fired = fired_q;
        guess.busy_res     = train_q;
        predicted_drive_q.push_back(guess);
        waiting++;
      end
    end
  end

endmodule

// ----- tb/sv/solenoid_pulse_train_generator_top_test.sv -----
module solenoid_pulse_train_generator_top_test;
  import sptg_pkg::*;

  localparam logic [2:0]           CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]           CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0]           CMD_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX   = 2'd3;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 1000;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_EVERY_THIRD} flow_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int chk_fails;
  int pending;
  int results;
  int pulses;

  in_item_t    cmd_q[$];
  logic [31:0] clock_ms = '0;
  int unsigned step_max = 2000 / 4 + 2;
  bit          hold_req = 1'b0;
  int          sent = 0;
  int          writes = 0;
  int          settings = 1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  solenoid_pulse_train_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  solenoid_pulse_train_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(chk_fails),
    .pending_o   (pending),
    .results_o   (results),
    .pulses_o    (pulses)
  );

  task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] now, input logic [7:0] cnt);
    in_item_t it;
    it.cmd         = cmd;
    it.now_ms      = now;
    it.pulse_count = cnt;
    cmd_q.push_back(it);
  endtask

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    it.cmd         = CMD_TICK;
    it.now_ms      = $urandom();
    it.pulse_count = 8'($urandom());
    if (pick < 72) begin
      clock_ms  = clock_ms + $urandom_range(0, step_max);
      it.now_ms = clock_ms;
    end else if (pick < 80) begin
      it.cmd = CMD_ARM;
      if ($urandom_range(0, 7) != 0) it.pulse_count = 8'($urandom_range(0, 3));
    end else if (pick < 84) begin
      it.cmd    = CMD_SET_TIME;
      clock_ms  = clock_ms + $urandom_range(0, step_max);
      it.now_ms = clock_ms;
    end else if (pick < 87) begin
      it.cmd = CMD_FORCE_ON;
    end else if (pick < 90) begin
      it.cmd = CMD_FORCE_OFF;
    end else if (pick < 93) begin
      it.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end else if (pick < 96) begin
      // jump anywhere on the time base
      clock_ms = it.now_ms;
    end else begin
      it.now_ms = clock_ms;
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    writes++;
  endtask

  task automatic program_setting(input logic [15:0] period, input logic [15:0] duty_word,
                                 input logic [15:0] level_word);
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_DUTY, duty_word);
    write_reg(CFG_LEVEL, level_word);
    step_max = period / 4 + 2;
    settings++;
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || in_valid_i || pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : sender
    int burst_left;
    int gap_left;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    burst_left = 1;
    gap_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) sent++;
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_item_i  <= cmd_q.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  initial begin : receiver
    int    seg_left;
    int    hold_left;
    int    cyc;
    flow_e mode;
    out_stall_i <= 1'b0;
    seg_left  = 0;
    hold_left = 0;
    cyc       = 0;
    mode      = FLOW_FREE;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          mode     = flow_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          FLOW_FREE: out_stall_i <= 1'b0;
          FLOW_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 30);
          FLOW_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 75);
          default: out_stall_i <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("solenoid_pulse_train_generator_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int leftover;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_PERIOD;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: on-time 200, off-time 1800
    queue_cmd(CMD_TICK, 32'd0, 8'd0);
    queue_cmd(CMD_SET_TIME, 32'hFFFF_FFFF, 8'hFF);
    queue_cmd(CMD_SPARE_FIRST, 32'h5555_5555, 8'h55);
    queue_cmd(CMD_SPARE_MID, 32'hAAAA_AAAA, 8'hAA);
    queue_cmd(CMD_SPARE_LAST, 32'hFFFF_FFFF, 8'hFF);
    queue_cmd(CMD_ARM, 32'd0, 8'd0);
    queue_cmd(CMD_TICK, 32'd0, 8'd0);
    queue_cmd(CMD_TICK, 32'd200, 8'd0);
    queue_cmd(CMD_TICK, 32'd201, 8'd0);
    queue_cmd(CMD_TICK, 32'd2001, 8'd0);
    queue_cmd(CMD_TICK, 32'd2002, 8'd0);
    queue_cmd(CMD_TICK, 32'd3000, 8'd0);
    queue_cmd(CMD_ARM, 32'hFFFF_FFFF, 8'd255);
    queue_cmd(CMD_TICK, 32'd4000, 8'd0);
    queue_cmd(CMD_FORCE_OFF, 32'd0, 8'd0);
    queue_cmd(CMD_FORCE_ON, 32'd0, 8'd0);
    queue_cmd(CMD_TICK, 32'hFFFF_FFFF, 8'hFF);
    queue_cmd(CMD_TICK, 32'd5, 8'd0);
    queue_cmd(CMD_TICK, 32'd1806, 8'd0);
    queue_cmd(CMD_SET_TIME, 32'd0, 8'd0);
    queue_cmd(CMD_FORCE_ON, 32'd0, 8'd0);
    queue_cmd(CMD_TICK, 32'd0, 8'd0);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          program_setting(16'd20, 16'd50, 16'd0);
          clock_ms = 32'hFFFF_FF80;
        end
        2: program_setting(16'd0, 16'd0, 16'd1);
        3: begin
          program_setting(16'hFFFF, 16'd100, 16'd1);
          hold_req = 1'b1;
        end
        4: program_setting(16'hFFFF, 16'd0, 16'd0);
        5: begin
          write_reg(CFG_SPARE_IDX, 16'($urandom()));
          program_setting(16'd7, 16'd127, 16'd1);
        end
        6: program_setting(16'd1, 16'd1, 16'd0);
        7: program_setting(16'($urandom_range(0, 300)), 16'($urandom()), 16'($urandom()));
        default: begin
          program_setting(16'($urandom()), 16'($urandom_range(0, 127)), 16'($urandom()));
          hold_req = 1'b1;
        end
      endcase
      repeat (4) @(posedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_q.push_back(random_command());
      settle();
    end

    leftover = pending;
    if (leftover != 0) $error("%0d expected results never arrived", leftover);
    $display("run covered %0d commands and %0d checked results over %0d register settings",
             sent, results, settings);
    $display("%0d register writes, %0d pulses completed by the predicted solenoid",
             writes, pulses);
    if (chk_fails == 0 && leftover == 0)
      $display("solenoid_pulse_train_generator_top verification clean");
    else
      $display("solenoid_pulse_train_generator_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sptg_pkg.sv
rtl/core/solenoid_pulse_train_generator_top.sv
tb/sv/solenoid_pulse_train_checker.sv
tb/sv/solenoid_pulse_train_generator_top_test.sv
